[sv/ubxr_pkg.sv]
package ubxr_pkg;

    localparam int MAX_BODY   = 1023;
    localparam int LEN_W      = 10;
    localparam int POS_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_LENGTH = 2'd2;

    localparam logic [7:0]       SYNC_FIRST_RST  = 8'hB5;
    localparam logic [7:0]       SYNC_SECOND_RST = 8'h62;
    localparam logic [LEN_W-1:0] BODY_LENGTH_RST = 10'd96;

    typedef struct packed {
        logic [7:0]       sync_first;
        logic [7:0]       sync_second;
        logic [LEN_W-1:0] body_length;
    } t_cfg;

    typedef struct packed {
        logic             body_valid;
        logic [LEN_W-1:0] body_index;
        logic [7:0]       body_byte;
        logic             frame_end;
        logic             frame_good;
    } t_result;

endpackage

[sv/ubx_frame_receiver.sv]
// UBX frame receiver. Takes one received byte per transfer, hunts for the two
// configured sync bytes, then passes body_length body bytes out with their
// index while keeping a Fletcher-8 checksum over them; a wrong first checksum
// byte ends the frame, else the second ends it, with frame_good on a match.
// Every input byte yields exactly one result, body bytes before the checksum
// is known. Throughput is one byte per clock while o_stall is low: position
// counter and checksum update together, and the result is registered in the
// output or skid entry. A two-entry output buffer lets the next byte be taken
// while a result waits; o_stall rises only when both entries are full.
// Configuration writes take effect on the next clock and belong to idle time.
module ubx_frame_receiver
    import ubxr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_body_valid,
    output logic [LEN_W-1:0]      o_body_index,
    output logic [7:0]            o_body_byte,
    output logic                  o_frame_end,
    output logic                  o_frame_good
);

    t_cfg    cfg;
    t_result step_result;
    t_result out_result;
    logic    full;
    logic    accept;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    ubxr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ubxr_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_rx_byte),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    ubxr_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_result (step_result),
        .o_full   (full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_result)
    );

    assign o_body_valid = out_result.body_valid;
    assign o_body_index = out_result.body_index;
    assign o_body_byte  = out_result.body_byte;
    assign o_frame_end  = out_result.frame_end;
    assign o_frame_good = out_result.frame_good;

endmodule

[sv/ubxr_cfg.sv]
module ubxr_cfg
    import ubxr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SYNC_FIRST:  n_cfg.sync_first  = i_cfg_data[7:0];
                CFG_SYNC_SECOND: n_cfg.sync_second = i_cfg_data[7:0];
                CFG_BODY_LENGTH: n_cfg.body_length = i_cfg_data[LEN_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= SYNC_FIRST_RST;
            r_cfg.sync_second <= SYNC_SECOND_RST;
            r_cfg.body_length <= BODY_LENGTH_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/ubxr_parser.sv]
module ubxr_parser
    import ubxr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    logic [POS_W-1:0] r_position;
    logic [POS_W-1:0] n_position;
    logic [7:0]       r_sum_a;
    logic [7:0]       n_sum_a;
    logic [7:0]       r_sum_b;
    logic [7:0]       n_sum_b;

    logic [POS_W-1:0] len;
    logic [POS_W-1:0] rel;
    logic [7:0]       sum_a_add;
    t_result          res;

    always_comb begin
        len = {1'b0, i_cfg.body_length};
        if (len > POS_W'(MAX_BODY)) begin
            len = POS_W'(MAX_BODY);
        end
    end

    assign rel       = r_position - POS_W'(2);
    assign sum_a_add = r_sum_a + i_byte;

    always_comb begin
        n_position = r_position;
        n_sum_a    = r_sum_a;
        n_sum_b    = r_sum_b;
        res        = '0;
        case (r_position)
            POS_W'(0): begin
                n_position = (i_byte == i_cfg.sync_first) ? POS_W'(1) : POS_W'(0);
            end
            POS_W'(1): begin
                if (i_byte == i_cfg.sync_second) begin
                    n_position = POS_W'(2);
                    n_sum_a    = '0;
                    n_sum_b    = '0;
                end else begin
                    n_position = '0;
                end
            end
            default: begin
                if (rel < len) begin
                    res.body_valid = 1'b1;
                    res.body_index = rel[LEN_W-1:0];
                    res.body_byte  = i_byte;
                    n_sum_a        = sum_a_add;
                    n_sum_b        = r_sum_b + sum_a_add;
                    n_position     = r_position + POS_W'(1);
                end else if (rel == len) begin
                    if (i_byte == r_sum_a) begin
                        n_position = r_position + POS_W'(1);
                    end else begin
                        res.frame_end = 1'b1;
                        n_position    = '0;
                    end
                end else if (rel == len + POS_W'(1)) begin
                    res.frame_end  = 1'b1;
                    res.frame_good = (i_byte == r_sum_b);
                    n_position     = '0;
                end else begin
                    // length shrank under an open frame: give up on it
                    n_position = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_sum_a    <= '0;
            r_sum_b    <= '0;
        end else if (i_accept) begin
            r_position <= n_position;
            r_sum_a    <= n_sum_a;
            r_sum_b    <= n_sum_b;
        end
    end

    assign o_result = res;

`ifndef SYNTH
    a_end_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && res.frame_end) |=> (r_position == '0))
        else $error("frame end did not return to hunting");

    a_good_needs_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.frame_good |-> (res.frame_end && !res.body_valid))
        else $error("frame_good without frame_end");

    a_body_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && res.body_valid) |=> (r_position == $past(r_position) + POS_W'(1)))
        else $error("body byte did not advance position");

    a_sync_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_position == POS_W'(1) && n_position == POS_W'(2))
        |=> (r_sum_a == '0 && r_sum_b == '0))
        else $error("checksum not cleared at sync");
`endif

endmodule

[sv/ubxr_skid.sv]
module ubxr_skid
    import ubxr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_result i_result,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_accept;
            end
        end else if (i_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end else if (i_accept) begin
            // park the transfer while the output holds
            r_skid <= i_result;
        end
    end

    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTH
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry without output entry");

    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_accept)
        else $error("transfer accepted with skid full");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");
`endif

endmodule

[tb/tb_ubx_frame_receiver.sv]
module tb_ubx_frame_receiver;
    import ubxr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_SYNC2,
        FLAW_BAD_CK_A,
        FLAW_BAD_CK_B,
        FLAW_CUT
    } t_flaw;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    logic [7:0]            i_rx_byte   = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    logic                  o_body_valid;
    logic [LEN_W-1:0]      o_body_index;
    logic [7:0]            o_body_byte;
    logic                  o_frame_end;
    logic                  o_frame_good;

    ubx_frame_receiver dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_body_valid (o_body_valid),
        .o_body_index (o_body_index),
        .o_body_byte  (o_body_byte),
        .o_frame_end  (o_frame_end),
        .o_frame_good (o_frame_good)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver-side shadow of the block
    t_cfg             cfg_now = '{SYNC_FIRST_RST, SYNC_SECOND_RST, BODY_LENGTH_RST};
    logic [POS_W-1:0] frame_pos = '0;
    logic [7:0]       run_ck_a  = '0;
    logic [7:0]       run_ck_b  = '0;

    logic [7:0] tx_bytes[$];
    t_result    pending_results[$];
    t_result    oldest_result;

    int unsigned bytes_issued = 0;
    int unsigned bytes_taken  = 0;
    int unsigned mismatches   = 0;
    int unsigned body_seen    = 0;
    int unsigned frames_good  = 0;
    int unsigned frames_bad   = 0;

    logic rx_done = 1'b0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   stall_pct = 0;

    function automatic t_result predict_byte(input logic [7:0] b);
        t_result r;
        int      len;
        int      rel;
        r = '0;
        len = (cfg_now.body_length > MAX_BODY) ? MAX_BODY : int'(cfg_now.body_length);
        if (frame_pos == 0) begin
            frame_pos = (b == cfg_now.sync_first) ? 1 : 0;
        end else if (frame_pos == 1) begin
            if (b == cfg_now.sync_second) begin
                frame_pos = 2;
                run_ck_a = '0;
                run_ck_b = '0;
            end else begin
                frame_pos = 0;
            end
        end else begin
            rel = int'(frame_pos) - 2;
            if (rel < len) begin
                r.body_valid = 1'b1;
                r.body_index = LEN_W'(rel);
                r.body_byte = b;
                run_ck_a = run_ck_a + b;
                run_ck_b = run_ck_b + run_ck_a;
                frame_pos = frame_pos + 1'b1;
            end else if (rel == len) begin
                if (b == run_ck_a) begin
                    frame_pos = frame_pos + 1'b1;
                end else begin
                    r.frame_end = 1'b1;
                    frame_pos = 0;
                end
            end else if (rel == len + 1) begin
                r.frame_end = 1'b1;
                r.frame_good = (b == run_ck_b);
                frame_pos = 0;
            end else begin
                // length shrank under an open frame: drop to hunting
                frame_pos = 0;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            mismatches++;
        end
    endtask

    // sender: bursts of random length with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !rx_done) begin
            // hold the stalled transfer
        end else if (gap_left != 0) begin
            i_valid <= 1'b0;
            gap_left--;
        end else if (tx_bytes.size() != 0) begin
            i_valid <= 1'b1;
            i_rx_byte <= tx_bytes.pop_front();
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end else begin
                burst_left--;
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // receiver: stall probability changes per segment, some segments never stall
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_left = $urandom_range(5, 40);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
        end else begin
            stall_left--;
        end
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        rx_done = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                pending_results.push_back(predict_byte(i_rx_byte));
                bytes_taken++;
                rx_done = 1'b1;
            end
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %h", $time,
                             {o_body_valid, o_body_index, o_body_byte, o_frame_end,
                              o_frame_good});
                    mismatches++;
                end else begin
                    oldest_result = pending_results.pop_front();
                    check_field("body_valid", oldest_result.body_valid, o_body_valid);
                    check_field("body_index", oldest_result.body_index, o_body_index);
                    check_field("body_byte", oldest_result.body_byte, o_body_byte);
                    check_field("frame_end", oldest_result.frame_end, o_frame_end);
                    check_field("frame_good", oldest_result.frame_good, o_frame_good);
                end
                if (o_body_valid) begin
                    body_seen++;
                end
                if (o_frame_end) begin
                    if (o_frame_good) begin
                        frames_good++;
                    end else begin
                        frames_bad++;
                    end
                end
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        bytes_issued++;
    endtask

    task automatic queue_frame(input t_flaw flaw);
        int unsigned n_body;
        logic [7:0]  ck_a;
        logic [7:0]  ck_b;
        logic [7:0]  b;
        n_body = cfg_now.body_length;
        queue_byte(cfg_now.sync_first);
        if (flaw == FLAW_BAD_SYNC2) begin
            queue_byte(cfg_now.sync_second ^ 8'($urandom_range(1, 255)));
            return;
        end
        queue_byte(cfg_now.sync_second);
        if (flaw == FLAW_CUT) begin
            n_body = (n_body == 0) ? 0 : $urandom_range(0, n_body - 1);
        end
        ck_a = '0;
        ck_b = '0;
        for (int unsigned k = 0; k < n_body; k++) begin
            b = 8'($urandom);
            queue_byte(b);
            ck_a = ck_a + b;
            ck_b = ck_b + ck_a;
        end
        if (flaw == FLAW_CUT) begin
            return;
        end
        if (flaw == FLAW_BAD_CK_A) begin
            queue_byte(ck_a ^ 8'($urandom_range(1, 255)));
            return;
        end
        queue_byte(ck_a);
        queue_byte((flaw == FLAW_BAD_CK_B) ? ck_b ^ 8'($urandom_range(1, 255)) : ck_b);
    endtask

    // noise leans toward the first sync byte to exercise false starts
    task automatic queue_noise(input int n);
        for (int k = 0; k < n; k++) begin
            queue_byte(($urandom_range(0, 3) == 0) ? cfg_now.sync_first : 8'($urandom));
        end
    endtask

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (bytes_taken != bytes_issued || pending_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SYNC_FIRST:  cfg_now.sync_first = val[7:0];
            CFG_SYNC_SECOND: cfg_now.sync_second = val[7:0];
            CFG_BODY_LENGTH: cfg_now.body_length = val[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic run_phase(input logic [7:0] s1, input logic [7:0] s2,
                             input logic [LEN_W-1:0] len, input int n_items);
        int unsigned start;
        int          pick;
        // upper data bits are junk for the sync registers
        write_reg(CFG_SYNC_FIRST, {2'($urandom), s1});
        write_reg(CFG_SYNC_SECOND, {2'($urandom), s2});
        write_reg(CFG_BODY_LENGTH, len);
        start = bytes_issued;
        queue_frame(FLAW_NONE);
        while (bytes_issued - start < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                queue_frame(FLAW_NONE);
            end else if (pick < 70) begin
                queue_frame(FLAW_BAD_CK_A);
            end else if (pick < 78) begin
                queue_frame(FLAW_BAD_CK_B);
            end else if (pick < 84) begin
                queue_frame(FLAW_BAD_SYNC2);
            end else if (pick < 90) begin
                queue_frame(FLAW_CUT);
            end else begin
                queue_noise($urandom_range(1, 6));
            end
        end
        // leave a frame open now and then so the next length lands mid-frame
        if ($urandom_range(0, 1) == 0) begin
            queue_frame(FLAW_CUT);
        end
        wait_idle();
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // false starts under reset settings; a repeated first sync byte is not retried
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(cfg_now.sync_first);
        queue_byte(cfg_now.sync_first);
        queue_byte(cfg_now.sync_second);
        // open a frame, then shrink the length beneath it
        queue_byte(cfg_now.sync_first);
        queue_byte(cfg_now.sync_second);
        queue_byte(8'h11);
        queue_byte(8'h22);
        queue_byte(8'h33);
        wait_idle();
        write_reg(CFG_BODY_LENGTH, 10'd1);
        queue_byte(8'h44);
        wait_idle();
        write_reg(CFG_BODY_LENGTH, 10'd0);
        queue_frame(FLAW_NONE);
        wait_idle();
        write_reg(CFG_BODY_LENGTH, 10'd2);
        queue_frame(FLAW_BAD_CK_A);
        queue_frame(FLAW_BAD_CK_B);
        wait_idle();

        run_phase(8'hB5, 8'h62, 10'd96, 80);
        run_phase(8'h00, 8'hFF, 10'd0, 60);
        run_phase(8'hFF, 8'h00, 10'd1, 60);
        run_phase(8'h5A, 8'h5A, 10'd5, 80);
        run_phase(8'($urandom), 8'($urandom), LEN_W'($urandom_range(2, 12)), 80);
        run_phase(8'hB5, 8'h62, 10'd260, 1);
        run_phase(8'($urandom), 8'($urandom), 10'd3, 60);
        run_phase(8'h62, 8'hB5, 10'd16, 80);

        wait_idle();
        repeat (20) @(negedge i_clk);
        $display("Run covered %0d bytes: %0d body bytes, %0d good and %0d failed frames,",
                 bytes_taken, body_seen, frames_good, frames_bad);
        $display("body lengths 0 to 260, edge sync values and mid-frame length changes.");
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d bytes taken of %0d", bytes_taken, bytes_issued);
        $display("== FAIL ==");
        $finish;
    end

endmodule

[ubx_frame_receiver.f]
sv/ubxr_pkg.sv
sv/ubxr_cfg.sv
sv/ubxr_parser.sv
sv/ubxr_skid.sv
sv/ubx_frame_receiver.sv
tb/tb_ubx_frame_receiver.sv
